FILE: rtl/core/wmma_pkg.sv
// Package for the window min/max/average core: sizes, register indexes,
// and the command/status structs between controller and datapath.
// No dependencies.
package wmma_pkg;

  localparam int DEPTH       = 64;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int SAMPLE_BITS = 32;
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
  localparam int TIME_W      = 32;
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE = 2'd0,
    REG_TRACK       = 2'd1,
    REG_SUPPLIED_T  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic accept;
    logic upd;
    logic scan;
    logic apply;
    logic div;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic div_done;
  } sts_t;

endpackage

FILE: rtl/core/wmma_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on wmma_pkg.
interface wmma_in_if import wmma_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic        [TIME_W-1:0]      stamp;
  modport source (output valid, sample, stamp, input ready);
  modport sink (input valid, sample, stamp, output ready);
endinterface

interface wmma_out_if import wmma_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_min;
  logic signed [SAMPLE_BITS-1:0] window_max;
  logic signed [SAMPLE_BITS-1:0] average;
  logic        [CNT_W-1:0]       sample_count;
  logic signed [SAMPLE_BITS-1:0] life_min;
  logic        [TIME_W-1:0]      life_min_time;
  logic signed [SAMPLE_BITS-1:0] life_max;
  logic        [TIME_W-1:0]      life_max_time;
  modport source (output valid, window_min, window_max, average, sample_count,
                  life_min, life_min_time, life_max, life_max_time, input ready);
  modport sink (input valid, window_min, window_max, average, sample_count,
                life_min, life_min_time, life_max, life_max_time, output ready);
endinterface

FILE: rtl/core/wmma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wmma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/wmma_ctrl.sv
// Sequencer for the window statistics core: steps one item through
// update, optional rescan, apply, divide and output load. Depends on wmma_pkg.
module wmma_ctrl import wmma_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_SCAN, S_APPLY, S_DIV, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.upd      = (state_r == S_UPD);
    cmd.scan     = (state_r == S_SCAN);
    cmd.apply    = (state_r == S_APPLY);
    cmd.div      = (state_r == S_DIV);
    cmd.out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_UPD;
      S_UPD:   state_nxt = sts.need_scan ? S_SCAN : S_APPLY;
      S_SCAN:  if (sts.scan_done) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_DIV;
      S_DIV:   if (sts.div_done) state_nxt = S_FIN;
      S_FIN:   if (cmd.out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
endmodule

FILE: rtl/core/wmma_dp.sv
// Datapath: config registers, sample ring RAM, running sum, extremes,
// rescan walker and serial divider. Depends on wmma_pkg and wmma_ram.
module wmma_dp import wmma_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  cmd_t                          cmd,
  output sts_t                          sts,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic        [TIME_W-1:0]      in_stamp,
  output logic signed [SAMPLE_BITS-1:0] window_min,
  output logic signed [SAMPLE_BITS-1:0] window_max,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic        [CNT_W-1:0]       sample_count,
  output logic signed [SAMPLE_BITS-1:0] life_min,
  output logic        [TIME_W-1:0]      life_min_time,
  output logic signed [SAMPLE_BITS-1:0] life_max,
  output logic        [TIME_W-1:0]      life_max_time
);
  logic [CNT_W-1:0] ws_r;
  logic             track_r, sup_r;
  logic signed [SAMPLE_BITS-1:0] sample_r, cur_min_r, cur_max_r, low_r, high_r;
  logic [TIME_W-1:0] ts_r, item_cnt_r, low_t_r, high_t_r;
  logic [ADDR_W-1:0] oldest_r, next_r;
  logic [CNT_W-1:0]  count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]  scan_idx_r;
  logic              scan_vld_r, scan_first_r, scan_min_r;
  logic [SUM_W-1:0]  div_q_r;
  logic [CNT_W-1:0]  div_rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic              div_neg_r;
  logic signed [SAMPLE_BITS-1:0] o_min_r, o_max_r, o_avg_r, o_low_r, o_high_r;
  logic [CNT_W-1:0]  o_cnt_r;
  logic [TIME_W-1:0] o_low_t_r, o_high_t_r;

  logic [CNT_W-1:0]  size_eff;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic signed [SAMPLE_BITS-1:0] dropped;
  logic              full;
  logic [CNT_W-1:0]  next_inc, oldest_inc;
  logic signed [SUM_W-1:0] s_ext, d_ext;

  // update-step results
  logic [CNT_W-1:0]  u_count;
  logic [ADDR_W-1:0] u_oldest, u_next;
  logic signed [SUM_W-1:0] u_sum;
  logic signed [SAMPLE_BITS-1:0] u_min, u_max, u_low, u_high;
  logic [TIME_W-1:0] u_low_t, u_high_t;
  logic              u_scan_min, u_scan_max;

  logic              scan_issue;
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;
  logic [SUM_W-1:0]  sum_mag, quot;

  always_comb begin
    if (ws_r == '0) size_eff = CNT_W'(1);
    else if (ws_r > CNT_W'(DEPTH)) size_eff = CNT_W'(DEPTH);
    else size_eff = ws_r;
  end

  assign ram_raddr = cmd.scan ? scan_idx_r[ADDR_W-1:0] : oldest_r;

  wmma_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_hist (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (next_r),
    .wdata (sample_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign dropped    = ram_rdata;
  assign full       = (count_r != '0) && !(count_r < size_eff);
  assign next_inc   = {1'b0, next_r} + CNT_W'(1);
  assign oldest_inc = {1'b0, oldest_r} + CNT_W'(1);
  assign s_ext      = {{ADDR_W{sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign d_ext      = {{ADDR_W{dropped[SAMPLE_BITS-1]}}, dropped};

  always_comb begin
    u_count    = count_r;
    u_oldest   = oldest_r;
    u_next     = (next_inc >= size_eff) ? '0 : next_inc[ADDR_W-1:0];
    u_sum      = sum_r + s_ext;
    u_min      = cur_min_r;
    u_max      = cur_max_r;
    u_low      = low_r;
    u_high     = high_r;
    u_low_t    = low_t_r;
    u_high_t   = high_t_r;
    u_scan_min = 1'b0;
    u_scan_max = 1'b0;
    if (count_r == '0) begin
      u_count  = CNT_W'(1);
      u_min    = sample_r;
      u_max    = sample_r;
      u_low    = sample_r;
      u_high   = sample_r;
      u_low_t  = ts_r;
      u_high_t = ts_r;
    end else begin
      if (full) begin
        u_oldest = (oldest_inc >= size_eff) ? '0 : oldest_inc[ADDR_W-1:0];
        u_sum    = sum_r + s_ext - d_ext;
        // dropped extreme: rescan, or fall back to the lifetime value
        if (dropped <= cur_min_r) begin
          if (track_r) u_scan_min = 1'b1;
          else u_min = low_r;
        end else if (dropped >= cur_max_r) begin
          if (track_r) u_scan_max = 1'b1;
          else u_max = high_r;
        end
      end else begin
        u_count = count_r + CNT_W'(1);
      end
      if (sample_r < low_r) begin
        u_low   = sample_r;
        u_low_t = ts_r;
      end else if (sample_r > high_r) begin
        u_high   = sample_r;
        u_high_t = ts_r;
      end
    end
  end

  assign scan_issue = scan_idx_r < count_r;
  assign rem_sh     = {div_rem_r, div_q_r[SUM_W-1]};
  assign rem_ge     = rem_sh >= {1'b0, count_r};
  assign sum_mag    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign quot       = div_neg_r ? (~div_q_r + SUM_W'(1)) : div_q_r;

  assign sts.need_scan = u_scan_min || u_scan_max;
  assign sts.scan_done = !scan_issue && !scan_vld_r;
  assign sts.div_done  = (div_cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r       <= CNT_W'(DEPTH);
      track_r    <= 1'b0;
      sup_r      <= 1'b0;
      item_cnt_r <= '0;
      oldest_r   <= '0;
      next_r     <= '0;
      count_r    <= '0;
      sum_r      <= '0;
      cur_min_r  <= '0;
      cur_max_r  <= '0;
      low_r      <= '0;
      high_r     <= '0;
      low_t_r    <= '0;
      high_t_r   <= '0;
      scan_idx_r <= '0;
      scan_vld_r <= 1'b0;
      div_cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_SIZE: begin
            ws_r     <= cfg_data;
            oldest_r <= '0;
            next_r   <= '0;
            count_r  <= '0;
            sum_r    <= '0;
          end
          REG_TRACK:      track_r <= cfg_data[0];
          REG_SUPPLIED_T: sup_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (!sup_r) item_cnt_r <= item_cnt_r + TIME_W'(1);
      end
      if (cmd.upd) begin
        count_r    <= u_count;
        oldest_r   <= u_oldest;
        next_r     <= u_next;
        sum_r      <= u_sum;
        cur_min_r  <= u_min;
        cur_max_r  <= u_max;
        low_r      <= u_low;
        high_r     <= u_high;
        low_t_r    <= u_low_t;
        high_t_r   <= u_high_t;
        scan_idx_r <= '0;
        scan_vld_r <= 1'b0;
      end
      if (cmd.scan) begin
        if (scan_issue) scan_idx_r <= scan_idx_r + CNT_W'(1);
        scan_vld_r <= scan_issue;
        if (scan_vld_r) begin
          if (scan_min_r) begin
            if (scan_first_r || $signed(dropped) < cur_min_r) cur_min_r <= dropped;
          end else begin
            if (scan_first_r || $signed(dropped) > cur_max_r) cur_max_r <= dropped;
          end
        end
      end
      if (cmd.apply) begin
        // new sample against window extremes, for every item, after any rescan
        if (sample_r < cur_min_r) cur_min_r <= sample_r;
        else if (sample_r > cur_max_r) cur_max_r <= sample_r;
        div_cnt_r <= DIV_CNT_W'(SUM_W);
      end
      if (cmd.div && div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      ts_r     <= sup_r ? in_stamp : (item_cnt_r + TIME_W'(1));
    end
    if (cmd.upd) begin
      scan_first_r <= 1'b1;
      scan_min_r   <= u_scan_min;
    end
    if (cmd.scan && scan_vld_r) scan_first_r <= 1'b0;
    if (cmd.apply) begin
      div_q_r   <= sum_mag;
      div_rem_r <= '0;
      div_neg_r <= sum_r[SUM_W-1];
    end
    if (cmd.div && div_cnt_r != '0) begin
      div_rem_r <= rem_ge ? CNT_W'(rem_sh - {1'b0, count_r}) : rem_sh[CNT_W-1:0];
      div_q_r   <= {div_q_r[SUM_W-2:0], rem_ge};
    end
    if (cmd.out_load) begin
      o_min_r    <= cur_min_r;
      o_max_r    <= cur_max_r;
      o_avg_r    <= quot[SAMPLE_BITS-1:0];
      o_cnt_r    <= count_r;
      o_low_r    <= low_r;
      o_low_t_r  <= low_t_r;
      o_high_r   <= high_r;
      o_high_t_r <= high_t_r;
    end
  end

  assign window_min    = o_min_r;
  assign window_max    = o_max_r;
  assign average       = o_avg_r;
  assign sample_count  = o_cnt_r;
  assign life_min      = o_low_r;
  assign life_min_time = o_low_t_r;
  assign life_max      = o_high_r;
  assign life_max_time = o_high_t_r;

`ifndef ASSERT_OFF
  a_count_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= size_eff) else $error("window count above window size");
  a_ring_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, oldest_r} < size_eff) && ({1'b0, next_r} < size_eff))
    else $error("ring index outside window");
  a_size_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_WINDOW_SIZE |=> count_r == '0 && sum_r == '0)
    else $error("window not emptied by size write");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_cnt_r <= DIV_CNT_W'(SUM_W)) else $error("divider step count overrun");
`endif
endmodule

FILE: rtl/core/window_min_max_average_core.sv
// Window min/max/average core, top level. Depends on wmma_pkg, wmma_if,
// wmma_ctrl and wmma_dp (which holds the 64-entry sample RAM).
// An item passes update, an optional window rescan when a dropped extreme
// triggers one (one RAM read per cycle), apply, the 38-step restoring
// divider for the average, and the output register load.
// Throughput: one item at a time, next transfer in the cycle after the result
// loads; a result held in the output register stalls the next load.
// Reset (rst_n, synchronous): empty window, window_size 64, tracking and
// supplied time off, the internal statistics and the item counter zero.
module window_min_max_average_core import wmma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  wmma_in_if.sink              in_if,
  wmma_out_if.source           out_if
);
  cmd_t cmd;
  sts_t sts;

  // Sequencer: one item in flight; the next transfer is taken while the
  // previous result still sits in the output register.
  wmma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: ring, sum, extremes, rescan and divider, output register.
  wmma_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .in_sample     (in_if.sample),
    .in_stamp      (in_if.stamp),
    .window_min    (out_if.window_min),
    .window_max    (out_if.window_max),
    .average       (out_if.average),
    .sample_count  (out_if.sample_count),
    .life_min      (out_if.life_min),
    .life_min_time (out_if.life_min_time),
    .life_max      (out_if.life_max),
    .life_max_time (out_if.life_max_time)
  );
endmodule
